// ===== src/lbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbcs_pkg
// Shared widths, register indexes, reset values and types for the LED
// blink-code sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcs_pkg;

	localparam int COUNT_BITS   = 4;
	localparam int TIME_BITS    = 32;
	localparam int DUR_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [DUR_BITS-1:0] DEFAULT_ON_MS    = DUR_BITS'(150);
	localparam logic [DUR_BITS-1:0] DEFAULT_OFF_MS   = DUR_BITS'(150);
	localparam logic [DUR_BITS-1:0] DEFAULT_PAUSE_MS = DUR_BITS'(5000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ON_TIME    = 2'd0,
		REG_OFF_TIME   = 2'd1,
		REG_PAUSE_TIME = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]  now_ms;
		logic                  bypass;
		logic                  restart;
		logic [COUNT_BITS-1:0] blink_count;
	} item_t;

	typedef struct packed {
		logic led;
		logic active;
	} result_t;

	typedef struct packed {
		logic [DUR_BITS-1:0] on_time_ms;
		logic [DUR_BITS-1:0] off_time_ms;
		logic [DUR_BITS-1:0] pause_time_ms;
	} cfg_t;

	typedef struct packed {
		logic                  running;
		logic                  lit;
		logic [COUNT_BITS-1:0] blinks_done;
		logic [TIME_BITS-1:0]  last_change_ms;
		logic [COUNT_BITS-1:0] latched_count;
	} seq_state_t;

endpackage

`default_nettype wire

// ===== src/lbcs_if.sv =====
// ----------------------------------------------------------------------------
// lbcs_if
// Valid/ready channels of the LED blink-code sequencer: item in, result out,
// and the register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbcs_item_if import lbcs_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [TIME_BITS-1:0]  now_ms;
	logic                  bypass;
	logic                  restart;
	logic [COUNT_BITS-1:0] blink_count;

	modport source (output valid, output now_ms, output bypass, output restart,
		output blink_count, input ready);
	modport sink (input valid, input now_ms, input bypass, input restart,
		input blink_count, output ready);
endinterface

interface lbcs_result_if;
	logic valid;
	logic ready;
	logic led;
	logic active;

	modport source (output valid, output led, output active, input ready);
	modport sink (input valid, input led, input active, output ready);
endinterface

interface lbcs_cfg_if import lbcs_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DUR_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lbcs_step.sv =====
// ----------------------------------------------------------------------------
// lbcs_step
// Next-state logic of the blink sequence for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcs_step import lbcs_pkg::*; (
	input  wire seq_state_t cur,
	input  wire item_t      item,
	input  wire cfg_t       cfg,
	output seq_state_t      nxt,
	output result_t         res
);

	logic [TIME_BITS-1:0] elapsed;

	always_comb begin
		nxt = cur;
		// restart stamps a fresh sequence, then the ordinary update runs
		if (item.restart) begin
			nxt.running        = 1'b1;
			nxt.lit            = 1'b0;
			nxt.blinks_done    = '0;
			nxt.last_change_ms = item.now_ms;
			nxt.latched_count  = item.blink_count;
		end
		elapsed = item.now_ms - nxt.last_change_ms;

		if (item.bypass) begin
			nxt.running = 1'b0;
			nxt.lit     = 1'b0;
		end else if (!nxt.running) begin
			nxt.running        = 1'b1;
			nxt.lit            = 1'b0;
			nxt.blinks_done    = '0;
			nxt.last_change_ms = item.now_ms;
			nxt.latched_count  = item.blink_count;
		end else if (nxt.lit) begin
			if (elapsed >= TIME_BITS'(cfg.on_time_ms)) begin
				nxt.lit            = 1'b0;
				nxt.last_change_ms = item.now_ms;
				nxt.blinks_done    = nxt.blinks_done + COUNT_BITS'(1);
			end
		end else if (nxt.blinks_done >= nxt.latched_count) begin
			if (elapsed >= TIME_BITS'(cfg.pause_time_ms)) begin
				nxt.blinks_done    = '0;
				nxt.last_change_ms = item.now_ms;
			end
		end else if (elapsed >= TIME_BITS'(cfg.off_time_ms)) begin
			nxt.lit            = 1'b1;
			nxt.last_change_ms = item.now_ms;
		end

		res.led    = nxt.lit;
		res.active = nxt.running;
	end

endmodule

`default_nettype wire

// ===== src/led_blink_code_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// led_blink_code_sequencer_unit
// Blink-code generator for one LED: count pulses of on/off time, a pause,
// then repeat. Bypass darkens the LED and stops the sequence.
// ----------------------------------------------------------------------------
// Path: an item beat taken goes to the input register, then to the result
//   register, which offers it. Throughput: one item per cycle while result
//   beats are taken; the sequence state is updated in a single pass between the two.
// Reset: sequence idle, LED dark, counts and time stamp zero; on, off and
//   pause times return to 150, 150 and 5000 ms. Configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_code_sequencer_unit import lbcs_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	lbcs_item_if.sink     item,
	lbcs_result_if.source result,
	lbcs_cfg_if.sink      cfg
);

	// input register
	logic       valid_s1;
	item_t      item_s1;

	// sequence state and configuration
	seq_state_t state_q;
	cfg_t       cfg_q;

	// result register
	logic       res_valid_s2;
	result_t    res_s2;

	seq_state_t state_nxt;
	result_t    res_nxt;
	logic       advance;

	// The result register frees up when empty or when its beat is taken;
	// stage 1 moves on in the same cycle, so items stream without bubbles.
	assign advance    = !res_valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	lbcs_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Capture the item beat; payload holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.now_ms      <= item.now_ms;
			item_s1.bypass      <= item.bypass;
			item_s1.restart     <= item.restart;
			item_s1.blink_count <= item.blink_count;
		end
	end

	// Commit the sequence state only when the item moves into the result
	// register, so each item is applied exactly once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid  = res_valid_s2;
	assign result.led    = res_s2.led;
	assign result.active = res_s2.active;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_time_ms    <= DEFAULT_ON_MS;
			cfg_q.off_time_ms   <= DEFAULT_OFF_MS;
			cfg_q.pause_time_ms <= DEFAULT_PAUSE_MS;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ON_TIME:    cfg_q.on_time_ms    <= cfg.data;
				REG_OFF_TIME:   cfg_q.off_time_ms   <= cfg.data;
				REG_PAUSE_TIME: cfg_q.pause_time_ms <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire
